// ===== sv/tef_pkg.sv =====
// shared constants and types of the trapezoidal energy filter
package tef_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int LEN_W      = 9;
	localparam int SPAN_W     = 10;
	localparam int COEF_W     = 32;
	localparam int ENERGY_W   = 40;
	localparam int FRAC_SHIFT = 16;
	localparam int OUT_DEPTH  = 8;
	localparam int OUT_PTR_W  = 3;

	localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LEN  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SPAN = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_COEF_LEAD   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_COEF_GAP    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_COEF_TRAIL  = 3'd4;

	localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
	localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

	typedef struct packed {
		logic start_trace;
		logic in_window;
		logic at_base;
	} tef_flags_t;

endpackage

// ===== sv/trapezoid_energy_filter_core.sv =====
// trapezoidal energy filter with decay correction, top level
//
// Input stream s_*: one ADC sample per beat in s_tdata, s_tuser marks the first
// sample of a trace. Output stream m_*: one result per input beat, energy in
// m_tdata (signed integer, saturated), m_tuser high once the sample
// index exceeds l+m; energy is zero before that.
// Config port: cfg_we writes cfg_wdata to the register at cfg_addr (window_len,
// window_span, coef_lead, coef_gap, coef_trail); write only while no beat is
// in flight.
// The history memory holds running prefix sums of the samples, so each window
// sum is the difference of two entries. Three entries are read per beat from
// two single-write memories, with registered read outputs.
// Throughput: one beat per cycle while s_tready is high, through the six-stage
// datapath (read, window sums, multiply, add, baseline subtract, round and
// saturate).
// The results land in an 8-entry output queue; s_tready drops when beats in
// flight plus queued reach 8, so a stalled receiver backs up the input side
// without losing results.
// Reset clears the pointers, counts and baseline and starts a new trace; the
// history memory needs no clearing, only entries of the running trace are read.
module trapezoid_energy_filter_core #(
	parameter int HISTORY_DEPTH = 1024,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // sample
	input  logic                              s_tuser,   // start_trace
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tef_pkg::ENERGY_W-1:0]      m_tdata,   // energy
	output logic                              m_tuser,   // settled
	input  logic                              cfg_we,
	input  logic [tef_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [tef_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import tef_pkg::*;

	localparam int AW   = $clog2(HISTORY_DEPTH);
	localparam int CW   = (AW + 1 > 11) ? AW + 1 : 11;
	localparam int ACC_W = SAMPLE_BITS + AW;
	localparam int PW   = ACC_W + COEF_W;
	localparam int W_W  = PW + 2;
	localparam int QW   = (W_W + 1 - FRAC_SHIFT > ENERGY_W) ? W_W + 1 - FRAC_SHIFT
		: ENERGY_W + 1;
	localparam int DW   = QW + FRAC_SHIFT;
	localparam int LMAX = (HISTORY_DEPTH - 1) / 2;

	function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] pos,
		input logic [AW-1:0] k);
		logic [AW:0] d;
		d = {1'b0, pos} - {1'b0, k};
		if (d[AW]) begin
			d = d + (AW+1)'(HISTORY_DEPTH);
		end
		return d[AW-1:0];
	endfunction

	// configuration registers
	logic [LEN_W-1:0]         len_q;
	logic [SPAN_W-1:0]        span_q;
	logic signed [COEF_W-1:0] coef_lead_q;
	logic signed [COEF_W-1:0] coef_gap_q;
	logic signed [COEF_W-1:0] coef_trail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= LEN_W'(1);
			span_q       <= SPAN_W'(1);
			coef_lead_q  <= '0;
			coef_gap_q   <= '0;
			coef_trail_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_WINDOW_LEN:  len_q        <= cfg_wdata[LEN_W-1:0];
				CFG_WINDOW_SPAN: span_q       <= cfg_wdata[SPAN_W-1:0];
				CFG_COEF_LEAD:   coef_lead_q  <= cfg_wdata[COEF_W-1:0];
				CFG_COEF_GAP:    coef_gap_q   <= cfg_wdata[COEF_W-1:0];
				CFG_COEF_TRAIL:  coef_trail_q <= cfg_wdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped window lengths
	logic [CW-1:0] len_eff;
	logic [CW-1:0] span_eff;
	logic [CW-1:0] lm_eff;

	always_comb begin
		len_eff = CW'(len_q);
		if (len_eff == '0) begin
			len_eff = CW'(1);
		end
		if (len_eff > CW'(LMAX)) begin
			len_eff = CW'(LMAX);
		end
		span_eff = CW'(span_q);
		if (span_eff < len_eff) begin
			span_eff = len_eff;
		end
		if (span_eff > CW'(HISTORY_DEPTH - 1) - len_eff) begin
			span_eff = CW'(HISTORY_DEPTH - 1) - len_eff;
		end
		lm_eff = len_eff + span_eff;
	end

	// input side
	logic                   in_beat;
	logic                   out_beat;
	logic [SAMPLE_BITS-1:0] sample;
	logic [AW-1:0]          wp_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          n_idx;
	logic [CW-1:0]          cnt_next;
	logic [ACC_W-1:0]       acc_q;
	logic [OUT_PTR_W:0]     occ_q;
	tef_flags_t             flags_in;

	assign s_tready = (occ_q < (OUT_PTR_W+1)'(OUT_DEPTH));
	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;
	assign sample   = s_tdata[SAMPLE_BITS-1:0];
	assign n_idx    = s_tuser ? '0 : cnt_q;
	assign cnt_next = (n_idx + CW'(1) < lm_eff + CW'(1)) ? n_idx + CW'(1) : lm_eff + CW'(1);

	always_comb begin
		flags_in.start_trace = s_tuser;
		flags_in.in_window   = (n_idx >= lm_eff);
		flags_in.at_base     = (n_idx == lm_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			cnt_q <= '0;
			acc_q <= '0;
		end else if (in_beat) begin
			wp_q  <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			cnt_q <= cnt_next;
			acc_q <= acc_q + ACC_W'(sample);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + (OUT_PTR_W+1)'(in_beat) - (OUT_PTR_W+1)'(out_beat);
		end
	end

	// prefix sum memories: entry k holds the sum of all samples before sample k
	logic [ACC_W-1:0] hist_a [HISTORY_DEPTH];
	logic [ACC_W-1:0] hist_b [HISTORY_DEPTH];
	logic [AW-1:0]    addr_l;
	logic [AW-1:0]    addr_m;
	logic [AW-1:0]    addr_lm;

	assign addr_l  = wrap_sub(wp_q, len_eff[AW-1:0]);
	assign addr_m  = wrap_sub(wp_q, span_eff[AW-1:0]);
	assign addr_lm = wrap_sub(wp_q, lm_eff[AW-1:0]);

	logic [ACC_W-1:0] rd_l_s1;
	logic [ACC_W-1:0] rd_m_s1;
	logic [ACC_W-1:0] rd_lm_s1;

	always_ff @(posedge clk) begin
		if (in_beat) begin
			hist_a[wp_q] <= acc_q;
		end
		rd_l_s1 <= hist_a[addr_l];
		rd_m_s1 <= hist_a[addr_m];
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			hist_b[wp_q] <= acc_q;
		end
		rd_lm_s1 <= hist_b[addr_lm];
	end

	// datapath pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	tef_flags_t flags_s1, flags_s2, flags_s3, flags_s4, flags_s5;
	logic [ACC_W-1:0]       acc_s1;
	logic [ACC_W-1:0]       lead_s2;
	logic [ACC_W-1:0]       gap_s2;
	logic [ACC_W-1:0]       trail_s2;
	logic signed [PW-1:0]   p_lead_s3;
	logic signed [PW-1:0]   p_gap_s3;
	logic signed [PW-1:0]   p_trail_s3;
	logic signed [W_W-1:0]  w_s4;
	logic signed [W_W-1:0]  baseline_q;
	logic signed [W_W-1:0]  base_use;
	logic signed [DW-1:0]   diff_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_beat;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		flags_s1   <= flags_in;
		acc_s1     <= acc_q;
		flags_s2   <= flags_s1;
		trail_s2   <= acc_s1 - rd_l_s1;
		gap_s2     <= rd_l_s1 - rd_m_s1;
		lead_s2    <= rd_m_s1 - rd_lm_s1;
		flags_s3   <= flags_s2;
		p_lead_s3  <= $signed({1'b0, lead_s2}) * coef_lead_q;
		p_gap_s3   <= $signed({1'b0, gap_s2}) * coef_gap_q;
		p_trail_s3 <= $signed({1'b0, trail_s2}) * coef_trail_q;
		flags_s4   <= flags_s3;
		w_s4       <= W_W'(p_lead_s3) + W_W'(p_gap_s3) + W_W'(p_trail_s3);
		flags_s5   <= flags_s4;
		diff_s5    <= DW'(w_s4) - DW'(base_use);
	end

	assign base_use = flags_s4.start_trace ? '0 : baseline_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= '0;
		end else if (v_s4) begin
			if (flags_s4.at_base) begin
				baseline_q <= w_s4;
			end else if (flags_s4.start_trace) begin
				baseline_q <= '0;
			end
		end
	end

	// round half up, saturate
	logic signed [DW-1:0]       rnd;
	logic signed [QW-1:0]       q_val;
	logic signed [ENERGY_W-1:0] q_sat;
	logic                       live_s5;

	assign rnd     = diff_s5 + DW'(1 << (FRAC_SHIFT - 1));
	assign q_val   = rnd[DW-1:FRAC_SHIFT];
	assign live_s5 = flags_s5.in_window && !flags_s5.at_base;

	always_comb begin
		if (!q_val[QW-1] && (q_val[QW-2:ENERGY_W-1] != '0)) begin
			q_sat = ENERGY_MAX;
		end else if (q_val[QW-1] && (q_val[QW-2:ENERGY_W-1] != '1)) begin
			q_sat = ENERGY_MIN;
		end else begin
			q_sat = q_val[ENERGY_W-1:0];
		end
	end

	// output queue
	logic [ENERGY_W-1:0]  oq_energy [OUT_DEPTH];
	logic                 oq_settled [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] oq_wr_q;
	logic [OUT_PTR_W-1:0] oq_rd_q;
	logic [OUT_PTR_W:0]   oq_cnt_q;

	always_ff @(posedge clk) begin
		if (v_s5) begin
			oq_energy[oq_wr_q]  <= live_s5 ? q_sat : '0;
			oq_settled[oq_wr_q] <= live_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (v_s5) begin
				oq_wr_q <= oq_wr_q + OUT_PTR_W'(1);
			end
			if (out_beat) begin
				oq_rd_q <= oq_rd_q + OUT_PTR_W'(1);
			end
			oq_cnt_q <= oq_cnt_q + (OUT_PTR_W+1)'(v_s5) - (OUT_PTR_W+1)'(out_beat);
		end
	end

	assign m_tvalid = (oq_cnt_q != '0);
	assign m_tdata  = oq_energy[oq_rd_q];
	assign m_tuser  = oq_settled[oq_rd_q];

endmodule

// ===== sv/tef_checker.sv =====
// port checker for the trapezoidal energy filter, bound to the top level
module tef_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [tef_pkg::ENERGY_W-1:0] m_tdata,
	input logic                         m_tuser
);
	import tef_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output beat changed while stalled");

	// no energy before the filter has settled
	a_unsettled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("nonzero energy on unsettled beat");

	// input backpressure only comes from results waiting at the output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// the first beat after reset finds the block ready
	a_ready_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> s_tready)
		else $error("not ready after reset");

endmodule

bind trapezoid_energy_filter_core tef_checker u_tef_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== bench/trapezoid_energy_filter_core_test.sv =====
// testbench of the trapezoidal energy filter: sample traces and config writes, every result beat checked
module trapezoid_energy_filter_core_test;

	import tef_pkg::*;

	localparam int HISTORY_DEPTH = 1024;
	localparam int SAMPLE_W      = 16;
	localparam int EDGE_COUNT    = 12;
	localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_UNUSED = CFG_COEF_TRAIL + CFG_ADDR_W'(1);
	localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [EDGE_COUNT] = '{
		16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
		16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h0001, 16'hFFFE
	};

	typedef struct {
		logic signed [ENERGY_W-1:0] energy;
		logic                       settled;
	} energy_result_t;

	class energy_scoreboard;
		logic [SAMPLE_W-1:0] history [HISTORY_DEPTH];
		int unsigned         wr_ptr;
		int unsigned         count;
		longint              base_whole;
		longint              base_part;
		logic [LEN_W-1:0]    len_reg;
		logic [SPAN_W-1:0]   span_reg;
		logic [COEF_W-1:0]   coef_lead;
		logic [COEF_W-1:0]   coef_gap;
		logic [COEF_W-1:0]   coef_trail;
		energy_result_t      expected [$];
		int                  errors;
		int                  checked;
		int                  settled_seen;
		int                  clipped_seen;
		int                  traces;

		function new();
			foreach (history[i]) history[i] = '0;
			wr_ptr = 0;
			count = 0;
			base_whole = 0;
			base_part = 0;
			len_reg = 1;
			span_reg = 1;
			coef_lead = '0;
			coef_gap = '0;
			coef_trail = '0;
			errors = 0;
			checked = 0;
			settled_seen = 0;
			clipped_seen = 0;
			traces = 0;
		endfunction

		function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
			case (addr)
				CFG_WINDOW_LEN: len_reg = data[LEN_W-1:0];
				CFG_WINDOW_SPAN: span_reg = data[SPAN_W-1:0];
				CFG_COEF_LEAD: coef_lead = data;
				CFG_COEF_GAP: coef_gap = data;
				CFG_COEF_TRAIL: coef_trail = data;
				default: ;
			endcase
		endfunction

		function int unsigned rise_len();
			int unsigned l;
			l = len_reg;
			if (l < 1) l = 1;
			if (l > (HISTORY_DEPTH - 1) / 2) l = (HISTORY_DEPTH - 1) / 2;
			return l;
		endfunction

		function int unsigned span_len();
			int unsigned l;
			int unsigned m;
			l = rise_len();
			m = span_reg;
			if (m < l) m = l;
			if (m > HISTORY_DEPTH - 1 - l) m = HISTORY_DEPTH - 1 - l;
			return m;
		endfunction

		function int unsigned window_total();
			return rise_len() + span_len();
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function longint win_sum(int unsigned pos, int unsigned from, int unsigned to);
			longint s;
			s = 0;
			for (int unsigned k = from; k <= to; k++)
				s += longint'(history[(pos + HISTORY_DEPTH - k) % HISTORY_DEPTH]);
			return s;
		endfunction

		function longint hi16(logic [COEF_W-1:0] c);
			return longint'($signed(c[31:16]));
		endfunction

		function longint lo16(logic [COEF_W-1:0] c);
			return longint'(c[15:0]);
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] smp, logic first);
			int unsigned    l;
			int unsigned    m;
			int unsigned    n;
			int unsigned    pos;
			longint         lead;
			longint         gap;
			longint         trail;
			longint         w_whole;
			longint         w_part;
			longint         q;
			energy_result_t r;
			l = rise_len();
			m = span_len();
			if (first) begin
				count = 0;
				base_whole = 0;
				base_part = 0;
				traces++;
			end
			n = count;
			pos = wr_ptr;
			history[pos] = smp;
			wr_ptr = (pos + 1) % HISTORY_DEPTH;
			r.energy = '0;
			r.settled = 1'b0;
			if (n >= l + m) begin
				lead = win_sum(pos, m + 1, l + m);
				gap = (m > l) ? win_sum(pos, l + 1, m) : 0;
				trail = win_sum(pos, 1, l);
				w_whole = lead * hi16(coef_lead) + gap * hi16(coef_gap) + trail * hi16(coef_trail);
				w_part = lead * lo16(coef_lead) + gap * lo16(coef_gap) + trail * lo16(coef_trail);
				if (n == l + m) begin
					base_whole = w_whole;
					base_part = w_part;
				end else begin
					q = (w_whole - base_whole) + ((w_part - base_part + 32768) >>> FRAC_SHIFT);
					if (q > ENERGY_MAX) q = ENERGY_MAX;
					if (q < ENERGY_MIN) q = ENERGY_MIN;
					r.energy = q[ENERGY_W-1:0];
					r.settled = 1'b1;
				end
			end
			count = (n + 1 < l + m + 1) ? n + 1 : l + m + 1;
			expected.push_back(r);
		endfunction

		function void check_result(logic [ENERGY_W-1:0] energy, logic settled);
			energy_result_t r;
			if (expected.size() == 0) begin
				errors++;
				if (errors <= 20)
					$display("%0t: result beat with nothing expected, energy %0d settled %0b",
						$time, $signed(energy), settled);
				return;
			end
			r = expected.pop_front();
			checked++;
			if (energy !== r.energy) begin
				errors++;
				if (errors <= 20)
					$display("%0t: energy expected %0d, got %0d", $time, r.energy, $signed(energy));
			end
			if (settled !== r.settled) begin
				errors++;
				if (errors <= 20)
					$display("%0t: settled expected %0b, got %0b", $time, r.settled, settled);
			end
			if (r.settled) begin
				settled_seen++;
				if (r.energy == ENERGY_MAX || r.energy == ENERGY_MIN) clipped_seen++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata = '0;   // sample
	logic                  s_tuser = 1'b0; // start_trace
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [ENERGY_W-1:0]   m_tdata;        // energy
	logic                  m_tuser;        // settled
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	energy_scoreboard sb;
	int burst_left = 0;
	int rx_cycle = 0;
	int rx_mode = 0;
	int setups = 0;
	int samples_sent = 0;

	trapezoid_energy_filter_core #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.SAMPLE_BITS(SAMPLE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// receiver stall pattern, redrawn at random from four modes
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
		if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= (rx_cycle % 4 == 0);
			default: m_tready <= (rx_cycle % 16 >= 10);
		endcase
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic first);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(smp, first);
		samples_sent++;
		burst_left--;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(addr, data);
	endtask

	task automatic load_config(input logic [31:0] len_v, input logic [31:0] span_v,
			input logic [31:0] c_lead, input logic [31:0] c_gap, input logic [31:0] c_trail);
		write_reg(CFG_WINDOW_LEN, len_v);
		write_reg(CFG_WINDOW_SPAN, span_v);
		write_reg(CFG_COEF_LEAD, c_lead);
		write_reg(CFG_COEF_GAP, c_gap);
		write_reg(CFG_COEF_TRAIL, c_trail);
		cfg_we <= 1'b0;
		setups++;
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return 32'h0;
			default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic random_setup();
		logic [31:0] len_v;
		logic [31:0] span_v;
		len_v = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8);
		span_v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len_v) : len_v + $urandom_range(0, 16);
		load_config(len_v, span_v, rand_coef(), rand_coef(), rand_coef());
	endtask

	initial begin
		int unsigned rand_items;
		int unsigned total;
		int unsigned tlen;
		int          n_traces;
		logic        keep_trace;
		sb = new();
		rand_items = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, first trace opened by reset alone
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h1234, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		drain();

		// zero length and span from masked writes, extreme weights, unused indexes
		load_config(32'hFFFF_FE00, 32'hFFFF_FC00, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		for (int k = 0; k < 3; k++) write_reg(CFG_FIRST_UNUSED + CFG_ADDR_W'(k), 32'h0000_0003);
		cfg_we <= 1'b0;
		for (int i = 0; i < EDGE_COUNT; i++) send_sample(EDGE_SAMPLES[i], i == 0 || i == 6);
		drain();

		// span shorter than length
		load_config(32'd3, 32'd2, 32'hFF00_0000, 32'h0000_8000, 32'h0100_0000);
		for (int i = 0; i < 9; i++) send_sample(16'(16'h1000 * (i + 1)), i == 0);
		drain();

		// longest windows, span past the history limit
		load_config(32'd511, 32'd1022, rand_coef() >>> 12, rand_coef() >>> 12, rand_coef() >>> 12);
		for (int i = 0; i < 16; i++)
			send_sample(SAMPLE_W'($urandom_range(16'hC000, 16'hFFFF)), i == 0);
		drain();

		// weights changed inside the trace, kept baseline, clipping both ways
		load_config(32'd70, 32'd70, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		for (int i = 0; i < 141; i++)
			send_sample(SAMPLE_W'($urandom_range(16'hF800, 16'hFFFF)), i == 0);
		drain();
		load_config(32'd70, 32'd70, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		for (int i = 0; i < 10; i++)
			send_sample(SAMPLE_W'($urandom_range(16'hF800, 16'hFFFF)), 1'b0);
		drain();
		for (int i = 0; i < 141; i++)
			send_sample(SAMPLE_W'($urandom_range(16'hF800, 16'hFFFF)), i == 0);
		drain();
		load_config(32'd70, 32'd70, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		for (int i = 0; i < 10; i++)
			send_sample(SAMPLE_W'($urandom_range(16'hF800, 16'hFFFF)), 1'b0);
		drain();

		while (rand_items < 80) begin
			random_setup();
			total = sb.window_total();
			n_traces = $urandom_range(1, 3);
			keep_trace = ($urandom_range(0, 4) == 0);
			for (int t = 0; t < n_traces; t++) begin
				tlen = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total) :
					total + $urandom_range(1, 24);
				for (int unsigned i = 0; i < tlen; i++) begin
					send_sample(rand_sample(),
						(i == 0 && !(t == 0 && keep_trace)) || ($urandom_range(0, 60) == 0));
					rand_items++;
				end
			end
			drain();
		end

		repeat (12) @(posedge clk);
		$display("%0d samples over %0d register setups and %0d traces", samples_sent, setups,
			sb.traces);
		$display("%0d results checked, %0d settled, %0d of them clipped", sb.checked,
			sb.settled_seen, sb.clipped_seen);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/tef_pkg.sv
sv/trapezoid_energy_filter_core.sv
sv/tef_checker.sv
bench/trapezoid_energy_filter_core_test.sv
